// ===== hdl/sha224_hash_engine_top_defines.svh =====
// assertion helpers shared by the sha224 checker
`ifndef SHA224_HASH_ENGINE_TOP_DEFINES_SVH
`define SHA224_HASH_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SHA_ASSERT_IMP(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sha224 check failed: same-cycle rule");

// next-cycle implication, checked out of reset
`define SHA_ASSERT_NXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sha224 check failed: next-cycle rule");

`endif

// ===== hdl/sha224_pkg.sv =====
`default_nettype none

package sha224_pkg;

    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int TOTAL_W     = 61;
    localparam int ROUNDS      = 64;
    localparam int BLK_WORDS   = 16;
    localparam int CHAIN_WORDS = 8;
    localparam int DIGEST_WORDS = 7;
    localparam int IDX_W       = 3;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [IDX_W-1:0]   widx_t;
    typedef logic [5:0]         bpos_t;
    typedef logic [3:0]         wsel_t;
    typedef word_t [CHAIN_WORDS-1:0] chain_t;

    localparam widx_t DIGEST_LAST = widx_t'(DIGEST_WORDS - 1);
    localparam byte_t PAD_MARK    = 8'h80;
    localparam bpos_t LEN_START   = 6'd56;

    // sha-224 initial chaining values
    localparam word_t INIT_HASH [CHAIN_WORDS] = '{
        32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
        32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
    };

    // round constants
    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // what the buffer presents for the block being compressed
    typedef enum logic [1:0] {
        BLK_DATA,       // buffer as written
        BLK_MARK,       // bytes, pad mark, zeros to the end
        BLK_MARK_LEN,   // bytes, pad mark, zeros, bit length
        BLK_LEN         // zeros, bit length
    } blk_kind_t;

    typedef struct packed {
        logic start;
        logic init;
    } core_ctl_t;

    typedef struct packed {
        logic      wr_en;
        bpos_t     wr_addr;
        byte_t     wr_data;
        blk_kind_t kind;
        total_t    total;
    } buf_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/sha224_msg_if.sv =====
`default_nettype none

interface sha224_msg_if;
    import sha224_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  has_byte;
    logic  message_end;

    modport source (
        output valid,
        output data_byte,
        output has_byte,
        output message_end,
        input  ready
    );

    modport sink (
        input  valid,
        input  data_byte,
        input  has_byte,
        input  message_end,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/sha224_dig_if.sv =====
`default_nettype none

interface sha224_dig_if;
    import sha224_pkg::*;

    logic  valid;
    logic  ready;
    word_t digest_word;
    widx_t word_index;
    logic  last_word;

    modport source (
        output valid,
        output digest_word,
        output word_index,
        output last_word,
        input  ready
    );

    modport sink (
        input  valid,
        input  digest_word,
        input  word_index,
        input  last_word,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/sha224_msgbuf.sv =====
`default_nettype none

module sha224_msgbuf (
    input  logic                 clk,
    input  sha224_pkg::buf_ctl_t ctl,
    input  sha224_pkg::wsel_t    rd_idx,
    output sha224_pkg::word_t    rd_word
);
    import sha224_pkg::*;

    logic [3:0][BYTE_W-1:0] mem_reg [BLK_WORDS];
    word_t                  rd_word_reg;
    word_t                  rd_word_next;

    // byte write, lane 3 holds the first byte of a word
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[ctl.wr_addr[5:2]][2'd3 - ctl.wr_addr[1:0]] <= ctl.wr_data;
        end
    end

    // word assembly with padding overlay
    always_comb
    begin
        logic [3:0][BYTE_W-1:0] row;
        logic [63:0]            len_bits;
        bpos_t                  pos;
        bpos_t                  p;
        logic                   in_len;
        byte_t                  b;
        byte_t                  len_b;
        row          = mem_reg[rd_idx];
        len_bits     = {ctl.total, 3'b000};
        pos          = ctl.total[5:0];
        rd_word_next = '0;
        for (int k = 0; k < 4; k++)
        begin
            p      = {rd_idx, 2'(k)};
            in_len = (p >= LEN_START);
            len_b  = len_bits[BYTE_W * (7 - int'(p[2:0])) +: BYTE_W];
            case (ctl.kind)
                BLK_DATA:
                begin
                    b = row[2'(3 - k)];
                end
                BLK_MARK, BLK_MARK_LEN:
                begin
                    if ((ctl.kind == BLK_MARK_LEN) && in_len)
                        b = len_b;
                    else if (p < pos)
                        b = row[2'(3 - k)];
                    else if (p == pos)
                        b = PAD_MARK;
                    else
                        b = '0;
                end
                BLK_LEN:
                begin
                    b = in_len ? len_b : '0;
                end
                default:
                begin
                    b = '0;
                end
            endcase
            rd_word_next[BYTE_W * (3 - k) +: BYTE_W] = b;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_word_reg <= rd_word_next;
    end

    assign rd_word = rd_word_reg;

endmodule

`default_nettype wire

// ===== hdl/sha224_core.sv =====
`default_nettype none

module sha224_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha224_pkg::core_ctl_t ctl,
    input  sha224_pkg::word_t     msg_word,
    output sha224_pkg::wsel_t     rd_idx,
    output logic                  done,
    output sha224_pkg::chain_t    chain
);
    import sha224_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_FIN
    } cstate_t;

    cstate_t    state_reg;
    logic [5:0] rnd_reg;
    chain_t     chain_reg;
    word_t      work_reg  [CHAIN_WORDS];
    word_t      sched_reg [BLK_WORDS];

    word_t w;
    word_t t1;
    word_t t2;

    function automatic word_t rotr(word_t x, int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t ssig0(word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    // schedule word: message for the first 16 rounds, then expansion
    // taps: sched_reg[i] holds w[t-16+i]
    always_comb
    begin
        if (rnd_reg[5:4] == 2'b00)
            w = msg_word;
        else
            w = sched_reg[0] + ssig0(sched_reg[1]) + sched_reg[9] + ssig1(sched_reg[14]);
    end

    // one round of the compression
    always_comb
    begin
        t1 = work_reg[7] + bsig1(work_reg[4])
           + (work_reg[6] ^ (work_reg[4] & (work_reg[5] ^ work_reg[6])))
           + ROUND_K[rnd_reg] + w;
        t2 = bsig0(work_reg[0])
           + ((work_reg[0] & work_reg[1]) | (work_reg[2] & (work_reg[0] | work_reg[1])));
    end

    // buffer prefetch: word 0 on start, next word during each round
    assign rd_idx = (state_reg == C_IDLE) ? '0 : 4'(rnd_reg + 6'd1);
    assign done   = (state_reg == C_FIN);
    assign chain  = chain_reg;

    // sequencer and chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            rnd_reg   <= '0;
            for (int i = 0; i < CHAIN_WORDS; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            case (state_reg)
                C_IDLE:
                begin
                    if (ctl.init)
                    begin
                        for (int i = 0; i < CHAIN_WORDS; i++)
                        begin
                            chain_reg[i] <= INIT_HASH[i];
                        end
                    end
                    if (ctl.start)
                    begin
                        rnd_reg   <= '0;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'(ROUNDS - 1))
                        state_reg <= C_FIN;
                end
                C_FIN:
                begin
                    for (int i = 0; i < CHAIN_WORDS; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // working variables and rolling schedule
    always_ff @(posedge clk)
    begin
        if ((state_reg == C_IDLE) && ctl.start)
        begin
            for (int i = 0; i < CHAIN_WORDS; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (state_reg == C_RUN)
        begin
            for (int i = 0; i < BLK_WORDS - 1; i++)
            begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[BLK_WORDS - 1] <= w;
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sha224_hash_engine_top.sv =====
// sha-224 hash engine, one message byte per beat
//
// msg channel (sink): data_byte, has_byte, message_end. has_byte marks a
// message byte; message_end closes the message after any byte of the same
// beat. A beat with neither flag is taken and ignored.
// dig channel (source): seven beats per message, digest_word with
// word_index 0..6 and last_word on the seventh.
//
// Bytes are taken one per cycle until a 64-byte block is full. A full block
// holds msg.ready low through one start step that loads the working
// words and fetches the first message word, 64 rounds on the single round
// unit and one chaining add. An end beat runs one padding block, or two when
// 56 or more bytes are pending in the block, plus the full block if that beat
// also completed one. The first digest beat is valid the cycle after the last
// compression; the seven beats then go out one per cycle while dig.ready is
// high. A stalled receiver simply holds the current beat; msg.ready stays low
// until the last digest beat is taken.
// Reset loads the initial chaining values and clears the byte count; the
// engine is ready in the first cycle after reset.
`default_nettype none

module sha224_hash_engine_top (
    input  logic          clk,
    input  logic          rst_n,
    sha224_msg_if.sink    msg,
    sha224_dig_if.source  dig
);
    import sha224_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_EMIT
    } state_t;

    state_t    state_reg, state_next;
    blk_kind_t kind_reg, kind_next;
    logic      end_pend_reg, end_pend_next;
    logic      start_reg, start_next;
    total_t    total_reg, total_next;
    widx_t     idx_reg, idx_next;

    logic      acc;
    logic      blk_full;
    total_t    total_add;
    logic      dig_beat;
    logic      dig_last;
    logic      core_done;
    chain_t    chain;
    wsel_t     rd_idx;
    word_t     msg_word;
    core_ctl_t core_ctl;
    buf_ctl_t  buf_ctl;

    function automatic blk_kind_t pad_kind(bpos_t p);
        return (p < LEN_START) ? BLK_MARK_LEN : BLK_MARK;
    endfunction

    // input side
    assign msg.ready = (state_reg == S_IDLE);
    assign acc       = msg.valid && msg.ready;
    assign blk_full  = msg.has_byte && (&total_reg[5:0]);
    assign total_add = msg.has_byte ? total_reg + total_t'(1) : total_reg;

    // digest side
    assign dig.valid       = (state_reg == S_EMIT);
    assign dig.digest_word = chain[idx_reg];
    assign dig.word_index  = idx_reg;
    assign dig_last        = (idx_reg == DIGEST_LAST);
    assign dig.last_word   = dig_last;
    assign dig_beat        = dig.valid && dig.ready;

    // buffer and round unit control
    always_comb
    begin
        buf_ctl.wr_en   = acc && msg.has_byte;
        buf_ctl.wr_addr = total_reg[5:0];
        buf_ctl.wr_data = msg.data_byte;
        buf_ctl.kind    = kind_reg;
        buf_ctl.total   = total_reg;
        core_ctl.start  = start_reg;
        core_ctl.init   = dig_beat && dig_last;
    end

    // block sequencing
    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        end_pend_next = end_pend_reg;
        start_next    = 1'b0;
        total_next    = total_reg;
        idx_next      = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    total_next = total_add;
                    if (blk_full)
                    begin
                        kind_next     = BLK_DATA;
                        end_pend_next = msg.message_end;
                        start_next    = 1'b1;
                        state_next    = S_HASH;
                    end
                    else if (msg.message_end)
                    begin
                        kind_next     = pad_kind(total_add[5:0]);
                        end_pend_next = 1'b0;
                        start_next    = 1'b1;
                        state_next    = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (core_done)
                begin
                    case (kind_reg)
                        BLK_DATA:
                        begin
                            if (end_pend_reg)
                            begin
                                kind_next     = pad_kind(total_reg[5:0]);
                                end_pend_next = 1'b0;
                                start_next    = 1'b1;
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        BLK_MARK:
                        begin
                            kind_next  = BLK_LEN;
                            start_next = 1'b1;
                        end
                        default:
                        begin
                            idx_next   = '0;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (dig_beat)
                begin
                    if (dig_last)
                    begin
                        idx_next   = '0;
                        total_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + widx_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            kind_reg     <= BLK_DATA;
            end_pend_reg <= 1'b0;
            start_reg    <= 1'b0;
            total_reg    <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            end_pend_reg <= end_pend_next;
            start_reg    <= start_next;
            total_reg    <= total_next;
            idx_reg      <= idx_next;
        end
    end

    sha224_msgbuf u_msgbuf (
        .clk     (clk),
        .ctl     (buf_ctl),
        .rd_idx  (rd_idx),
        .rd_word (msg_word)
    );

    sha224_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (core_ctl),
        .msg_word (msg_word),
        .rd_idx   (rd_idx),
        .done     (core_done),
        .chain    (chain)
    );

endmodule

`default_nettype wire

// ===== hdl/sha224_chk.sv =====
`default_nettype none
`include "sha224_hash_engine_top_defines.svh"

module sha224_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              msg_ready,
    input logic              dig_valid,
    input logic              dig_ready,
    input sha224_pkg::word_t dig_digest_word,
    input sha224_pkg::widx_t dig_word_index,
    input logic              dig_last_word
);
    import sha224_pkg::*;

    // no new message beat while the digest is going out
    `SHA_ASSERT_IMP(a_busy_while_emit, clk, rst_n, dig_valid, !msg_ready)

    // a digest always opens with word zero
    `SHA_ASSERT_IMP(a_first_word, clk, rst_n, $rose(dig_valid), dig_word_index == '0)

    // digest words follow back to back in order
    `SHA_ASSERT_NXT(a_word_order, clk, rst_n, dig_valid && dig_ready && !dig_last_word, dig_valid && (dig_word_index == $past(dig_word_index) + widx_t'(1)))

    // the last beat closes the digest
    `SHA_ASSERT_NXT(a_last_closes, clk, rst_n, dig_valid && dig_ready && dig_last_word, !dig_valid)

    // stalled digest beat holds
    `SHA_ASSERT_NXT(a_stall_holds, clk, rst_n, dig_valid && !dig_ready, dig_valid && $stable(dig_digest_word) && $stable(dig_word_index))

endmodule

bind sha224_hash_engine_top sha224_chk u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .msg_ready       (msg.ready),
    .dig_valid       (dig.valid),
    .dig_ready       (dig.ready),
    .dig_digest_word (dig.digest_word),
    .dig_word_index  (dig.word_index),
    .dig_last_word   (dig.last_word)
);

`default_nettype wire
